[rtl/vertex_normal_extrusion_assert.svh]
// Assertion macros for the vertex extrusion block
`ifndef VERTEX_NORMAL_EXTRUSION_ASSERT_SVH
`define VERTEX_NORMAL_EXTRUSION_ASSERT_SVH
`ifndef SYNTHESIS
`define VNE_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define VNE_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) cond |=> prop) else $error(msg);
`else
`define VNE_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define VNE_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg)
`endif
`endif

[rtl/vne_pkg.sv]
// Shared types and constants for the vertex extrusion block
package vne_pkg;
  localparam int NORM_BITS = 30;
  localparam int SQ_STEPS  = 31;   // root bits of a 62-bit sum of squares
  localparam int DIV_STEPS = 30;   // quotient bits of the unit normal below the top one
  localparam int LAT       = 1 + 1 + 1 + SQ_STEPS + DIV_STEPS + 1 + 1;

  typedef struct packed {
    logic skip;
    logic pass;
    logic sign_x;
    logic sign_y;
    logic sign_z;
  } ctl_t;
endpackage

[rtl/vne_sqrt_cell.sv]
// One bit step of the restoring square root; carries the vertex along
module vne_sqrt_cell #(
  parameter int STEP = 0,
  parameter int CW   = 32
) (
  input  logic                clk,
  input  logic                vld_i,
  input  logic [63:0]         rem_i,
  input  logic [31:0]         root_i,
  input  logic [30:0]         nx_i,
  input  logic [30:0]         ny_i,
  input  logic [30:0]         nz_i,
  input  logic [3*CW-1:0]     pos_i,
  input  logic [CW-1:0]       amag_i,
  input  vne_pkg::ctl_t       ctl_i,
  output logic                vld_o,
  output logic [63:0]         rem_o,
  output logic [31:0]         root_o,
  output logic [30:0]         nx_o,
  output logic [30:0]         ny_o,
  output logic [30:0]         nz_o,
  output logic [3*CW-1:0]     pos_o,
  output logic [CW-1:0]       amag_o,
  output vne_pkg::ctl_t       ctl_o
);
  localparam int SH = 2 * (vne_pkg::SQ_STEPS - 1 - STEP);
  logic [63:0] trial;
  logic [63:0] bitv;
  logic        ge;

  // try the next root bit: (2*r*2^k + 2^k)^2 - (2*r*2^k)^2
  always_comb begin
    bitv  = 64'd1 << SH;
    trial = ({32'd0, root_i} << (SH + 2)) + bitv;
    ge    = rem_i >= trial;
  end

  // advance to the neighbor
  always_ff @(posedge clk) begin
    vld_o  <= vld_i;
    rem_o  <= ge ? rem_i - trial : rem_i;
    root_o <= {root_i[30:0], ge};
    nx_o   <= nx_i;
    ny_o   <= ny_i;
    nz_o   <= nz_i;
    pos_o  <= pos_i;
    amag_o <= amag_i;
    ctl_o  <= ctl_i;
  end
endmodule

[rtl/vne_div_cell.sv]
// One quotient bit of the three unit-normal divisions
module vne_div_cell #(
  parameter int CW = 32
) (
  input  logic            clk,
  input  logic            vld_i,
  input  logic [31:0]     len_i,
  input  logic [32:0]     rx_i,
  input  logic [32:0]     ry_i,
  input  logic [32:0]     rz_i,
  input  logic [31:0]     qx_i,
  input  logic [31:0]     qy_i,
  input  logic [31:0]     qz_i,
  input  logic [3*CW-1:0] pos_i,
  input  logic [CW-1:0]   amag_i,
  input  vne_pkg::ctl_t   ctl_i,
  output logic            vld_o,
  output logic [31:0]     len_o,
  output logic [32:0]     rx_o,
  output logic [32:0]     ry_o,
  output logic [32:0]     rz_o,
  output logic [31:0]     qx_o,
  output logic [31:0]     qy_o,
  output logic [31:0]     qz_o,
  output logic [3*CW-1:0] pos_o,
  output logic [CW-1:0]   amag_o,
  output vne_pkg::ctl_t   ctl_o
);
  logic [33:0] sx, sy, sz, lw;

  // shift remainder, compare against the length
  always_comb begin
    lw = {2'd0, len_i};
    sx = {rx_i, 1'b0};
    sy = {ry_i, 1'b0};
    sz = {rz_i, 1'b0};
  end

  always_ff @(posedge clk) begin
    vld_o  <= vld_i;
    len_o  <= len_i;
    rx_o   <= (sx >= lw) ? 33'(sx - lw) : sx[32:0];
    ry_o   <= (sy >= lw) ? 33'(sy - lw) : sy[32:0];
    rz_o   <= (sz >= lw) ? 33'(sz - lw) : sz[32:0];
    qx_o   <= {qx_i[30:0], sx >= lw};
    qy_o   <= {qy_i[30:0], sy >= lw};
    qz_o   <= {qz_i[30:0], sz >= lw};
    pos_o  <= pos_i;
    amag_o <= amag_i;
    ctl_o  <= ctl_i;
  end
endmodule

[rtl/vertex_normal_extrusion.sv]
// Top level: vertex extrusion along the unit normal, one vertex per cycle
// Takes one vertex in every cycle (busy stays low); out_valid stays high for one
// cycle per result, and the beat is taken at the edge that ends that cycle; the
// receiver cannot stall. The pipeline is three entry stages, a row of 31
// square-root cells and 30 divider cells (one result bit per cell), a multiply
// stage and the output register. extrude_amount is to be written over APB at
// address 0 only while no vertex is in flight; the block does not enforce this.
module vertex_normal_extrusion #(
  parameter int FRAC_BITS   = 16,
  parameter int COORD_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] in_pos_x,
  input  logic signed [COORD_WIDTH-1:0] in_pos_y,
  input  logic signed [COORD_WIDTH-1:0] in_pos_z,
  input  logic signed [COORD_WIDTH-1:0] in_normal_x,
  input  logic signed [COORD_WIDTH-1:0] in_normal_y,
  input  logic signed [COORD_WIDTH-1:0] in_normal_z,
  output logic                          out_valid,
  output logic signed [COORD_WIDTH-1:0] out_new_x,
  output logic signed [COORD_WIDTH-1:0] out_new_y,
  output logic signed [COORD_WIDTH-1:0] out_new_z,
  output logic                          out_skipped,
  output logic                          out_saturated,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [1:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  `include "vertex_normal_extrusion_assert.svh"
  localparam int CW  = COORD_WIDTH;
  localparam int NSQ = vne_pkg::SQ_STEPS;
  localparam int NDV = vne_pkg::DIV_STEPS;
  localparam int MBW = $clog2(CW + 1);
  localparam logic [31:0] ADDR_AMOUNT = 32'd0;

  logic [CW-1:0] amount_r;
  logic          unused_frac;
  assign unused_frac = FRAC_BITS[0];

  // configuration port
  assign pready = 1'b1;
  assign prdata = 32'(amount_r);
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      amount_r <= '0;
    end else if (psel && penable && pwrite && (32'(paddr) == ADDR_AMOUNT)) begin
      amount_r <= CW'(pwdata);
    end
  end

  assign busy = 1'b0;

  function automatic logic [CW-1:0] mag(input logic [CW-1:0] v);
    mag = v[CW-1] ? CW'(~v + 1'b1) : v;
  endfunction

  // stage A: magnitudes, signs and the pass and skip flags
  logic          a_vld_r;
  logic [CW-1:0] a_nx_r, a_ny_r, a_nz_r, a_amag_r;
  logic [3*CW-1:0] a_pos_r;
  vne_pkg::ctl_t a_ctl_r;
  logic [CW-1:0] amag_in;
  assign amag_in = mag(amount_r);
  always_ff @(posedge clk) begin
    if (!rst_n) a_vld_r <= 1'b0;
    else a_vld_r <= start;
    a_nx_r   <= mag(in_normal_x);
    a_ny_r   <= mag(in_normal_y);
    a_nz_r   <= mag(in_normal_z);
    a_amag_r <= amag_in;
    a_pos_r  <= {in_pos_x, in_pos_y, in_pos_z};
    a_ctl_r.pass   <= (amag_in == '0);
    a_ctl_r.skip   <= (amag_in != '0) && (in_normal_x == '0) && (in_normal_y == '0)
                      && (in_normal_z == '0);
    a_ctl_r.sign_x <= amount_r[CW-1] ^ in_normal_x[CW-1];
    a_ctl_r.sign_y <= amount_r[CW-1] ^ in_normal_y[CW-1];
    a_ctl_r.sign_z <= amount_r[CW-1] ^ in_normal_z[CW-1];
  end

  // stage B: bit length of the largest magnitude, scale into [2^29, 2^30)
  logic [CW-1:0] mx;
  logic [MBW-1:0] blen;
  always_comb begin
    mx = (a_nx_r > a_ny_r) ? a_nx_r : a_ny_r;
    mx = (mx > a_nz_r) ? mx : a_nz_r;
    blen = '0;
    for (int k = 0; k < CW; k++) if (mx[k]) blen = MBW'(k + 1);
  end
  function automatic logic [30:0] scl(input logic [CW-1:0] v, input logic [MBW-1:0] b);
    logic [CW+30:0] w;
    w = {31'd0, v};
    if (32'(b) > 32'd30) scl = 31'(w >> (32'(b) - 32'd30));
    else scl = 31'(w << (32'd30 - 32'(b)));
  endfunction
  logic          b_vld_r;
  logic [30:0]   b_nx_r, b_ny_r, b_nz_r;
  logic [3*CW-1:0] b_pos_r;
  logic [CW-1:0] b_amag_r;
  vne_pkg::ctl_t b_ctl_r;
  always_ff @(posedge clk) begin
    if (!rst_n) b_vld_r <= 1'b0;
    else b_vld_r <= a_vld_r;
    b_nx_r <= scl(a_nx_r, blen);
    b_ny_r <= scl(a_ny_r, blen);
    b_nz_r <= scl(a_nz_r, blen);
    b_pos_r <= a_pos_r;
    b_amag_r <= a_amag_r;
    b_ctl_r <= a_ctl_r;
  end

  // stage C: sum of squares (three 31x31 products then add, registered)
  logic          c_vld_r;
  logic [63:0]   c_s_r;
  logic [30:0]   c_nx_r, c_ny_r, c_nz_r;
  logic [3*CW-1:0] c_pos_r;
  logic [CW-1:0] c_amag_r;
  vne_pkg::ctl_t c_ctl_r;
  always_ff @(posedge clk) begin
    if (!rst_n) c_vld_r <= 1'b0;
    else c_vld_r <= b_vld_r;
    c_s_r <= (64'(b_nx_r) * 64'(b_nx_r)) + (64'(b_ny_r) * 64'(b_ny_r))
             + (64'(b_nz_r) * 64'(b_nz_r));
    c_nx_r <= b_nx_r;
    c_ny_r <= b_ny_r;
    c_nz_r <= b_nz_r;
    c_pos_r <= b_pos_r;
    c_amag_r <= b_amag_r;
    c_ctl_r <= b_ctl_r;
  end

  // square root cells
  logic            sq_vld [NSQ+1];
  logic [63:0]     sq_rem [NSQ+1];
  logic [31:0]     sq_root[NSQ+1];
  logic [30:0]     sq_nx[NSQ+1], sq_ny[NSQ+1], sq_nz[NSQ+1];
  logic [3*CW-1:0] sq_pos[NSQ+1];
  logic [CW-1:0]   sq_amag[NSQ+1];
  vne_pkg::ctl_t   sq_ctl[NSQ+1];
  assign sq_vld[0] = c_vld_r;
  assign sq_rem[0] = c_s_r;
  assign sq_root[0] = '0;
  assign sq_nx[0] = c_nx_r;
  assign sq_ny[0] = c_ny_r;
  assign sq_nz[0] = c_nz_r;
  assign sq_pos[0] = c_pos_r;
  assign sq_amag[0] = c_amag_r;
  assign sq_ctl[0] = c_ctl_r;
  for (genvar g = 0; g < NSQ; g++) begin : g_sq
    vne_sqrt_cell #(.STEP(g), .CW(CW)) u_cell (
      .clk(clk), .vld_i(sq_vld[g]), .rem_i(sq_rem[g]), .root_i(sq_root[g]),
      .nx_i(sq_nx[g]), .ny_i(sq_ny[g]), .nz_i(sq_nz[g]), .pos_i(sq_pos[g]),
      .amag_i(sq_amag[g]), .ctl_i(sq_ctl[g]),
      .vld_o(sq_vld[g+1]), .rem_o(sq_rem[g+1]), .root_o(sq_root[g+1]),
      .nx_o(sq_nx[g+1]), .ny_o(sq_ny[g+1]), .nz_o(sq_nz[g+1]), .pos_o(sq_pos[g+1]),
      .amag_o(sq_amag[g+1]), .ctl_o(sq_ctl[g+1]));
  end

  // divider cells: u = (n << 30) / len
  logic            dv_vld [NDV+1];
  logic [31:0]     dv_len [NDV+1];
  logic [32:0]     dv_rx[NDV+1], dv_ry[NDV+1], dv_rz[NDV+1];
  logic [31:0]     dv_qx[NDV+1], dv_qy[NDV+1], dv_qz[NDV+1];
  logic [3*CW-1:0] dv_pos[NDV+1];
  logic [CW-1:0]   dv_amag[NDV+1];
  vne_pkg::ctl_t   dv_ctl[NDV+1];
  logic [31:0]     len0;
  logic            gx0, gy0, gz0;
  assign len0 = (sq_root[NSQ] == '0) ? 32'd1 : sq_root[NSQ];
  // n <= len, so the top quotient bit is set only when n equals len;
  // seed the remainder below len and shift in zeros for the lower 30 bits
  assign gx0 = {1'b0, sq_nx[NSQ]} >= len0;
  assign gy0 = {1'b0, sq_ny[NSQ]} >= len0;
  assign gz0 = {1'b0, sq_nz[NSQ]} >= len0;
  assign dv_vld[0] = sq_vld[NSQ];
  assign dv_len[0] = len0;
  assign dv_rx[0] = gx0 ? 33'd0 : {2'd0, sq_nx[NSQ]};
  assign dv_ry[0] = gy0 ? 33'd0 : {2'd0, sq_ny[NSQ]};
  assign dv_rz[0] = gz0 ? 33'd0 : {2'd0, sq_nz[NSQ]};
  assign dv_qx[0] = {31'd0, gx0};
  assign dv_qy[0] = {31'd0, gy0};
  assign dv_qz[0] = {31'd0, gz0};
  assign dv_pos[0] = sq_pos[NSQ];
  assign dv_amag[0] = sq_amag[NSQ];
  assign dv_ctl[0] = sq_ctl[NSQ];
  for (genvar g = 0; g < NDV; g++) begin : g_dv
    vne_div_cell #(.CW(CW)) u_cell (
      .clk(clk), .vld_i(dv_vld[g]), .len_i(dv_len[g]),
      .rx_i(dv_rx[g]), .ry_i(dv_ry[g]), .rz_i(dv_rz[g]),
      .qx_i(dv_qx[g]), .qy_i(dv_qy[g]), .qz_i(dv_qz[g]),
      .pos_i(dv_pos[g]), .amag_i(dv_amag[g]), .ctl_i(dv_ctl[g]),
      .vld_o(dv_vld[g+1]), .len_o(dv_len[g+1]),
      .rx_o(dv_rx[g+1]), .ry_o(dv_ry[g+1]), .rz_o(dv_rz[g+1]),
      .qx_o(dv_qx[g+1]), .qy_o(dv_qy[g+1]), .qz_o(dv_qz[g+1]),
      .pos_o(dv_pos[g+1]), .amag_o(dv_amag[g+1]), .ctl_o(dv_ctl[g+1]));
  end

  // stage M: offset product amag * u, rounded as (p + 2^29) >> 30 in stage R
  logic            m_vld_r;
  logic [CW+32:0]  m_px_r, m_py_r, m_pz_r;
  logic [3*CW-1:0] m_pos_r;
  vne_pkg::ctl_t   m_ctl_r;
  always_ff @(posedge clk) begin
    if (!rst_n) m_vld_r <= 1'b0;
    else m_vld_r <= dv_vld[NDV];
    m_px_r <= (CW+33)'(dv_amag[NDV]) * (CW+33)'(dv_qx[NDV]);
    m_py_r <= (CW+33)'(dv_amag[NDV]) * (CW+33)'(dv_qy[NDV]);
    m_pz_r <= (CW+33)'(dv_amag[NDV]) * (CW+33)'(dv_qz[NDV]);
    m_pos_r <= dv_pos[NDV];
    m_ctl_r <= dv_ctl[NDV];
  end

  // stage R: round, apply sign, add and clamp
  function automatic logic [CW:0] addc(input logic [CW-1:0] p, input logic [CW+32:0] pr,
                                       input logic neg);
    logic [CW+33:0] off;
    logic signed [CW+34:0] r;
    logic signed [CW+34:0] mx_v, mn_v;
    off  = (CW+34)'((pr + (CW+33)'(1 << 29)) >> 30);
    mx_v = (CW+35)'({1'b0, {(CW-1){1'b1}}});
    mn_v = -mx_v - 1;
    r = (CW+35)'(signed'(p)) + (neg ? -signed'({1'b0, off}) : signed'({1'b0, off}));
    if (r > mx_v) addc = {1'b1, mx_v[CW-1:0]};
    else if (r < mn_v) addc = {1'b1, mn_v[CW-1:0]};
    else addc = {1'b0, r[CW-1:0]};
  endfunction
  logic [CW:0] rx, ry, rz;
  assign rx = addc(m_pos_r[3*CW-1:2*CW], m_px_r, m_ctl_r.sign_x);
  assign ry = addc(m_pos_r[2*CW-1:CW], m_py_r, m_ctl_r.sign_y);
  assign rz = addc(m_pos_r[CW-1:0], m_pz_r, m_ctl_r.sign_z);
  logic keep;
  assign keep = m_ctl_r.pass || m_ctl_r.skip;
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else out_valid <= m_vld_r;
    out_new_x <= keep ? m_pos_r[3*CW-1:2*CW] : rx[CW-1:0];
    out_new_y <= keep ? m_pos_r[2*CW-1:CW] : ry[CW-1:0];
    out_new_z <= keep ? m_pos_r[CW-1:0] : rz[CW-1:0];
    out_skipped <= m_ctl_r.skip;
    out_saturated <= !keep && (rx[CW] || ry[CW] || rz[CW]);
  end

  `VNE_ASSERT_IMPL(a_busy_low, clk, rst_n, !busy, "busy raised")
  `VNE_ASSERT_NEXT(a_result_follows, clk, rst_n, m_vld_r, out_valid, "result beat dropped")
  `VNE_ASSERT_IMPL(a_skip_sat, clk, rst_n, !(out_valid && out_skipped && out_saturated), "skip with saturate")
endmodule

[tb/sv/tb_vertex_normal_extrusion.sv]
// Self-checking testbench for the vertex extrusion block
`timescale 1ns / 1ps

module tb_vertex_normal_extrusion;

  localparam logic [1:0] ADDR_EXTRUDE_AMOUNT = 2'd0;
  localparam int         DRAIN_CYCLES        = vne_pkg::LAT + 12;
  localparam int         STALL_LIMIT         = 5000;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] normal_x;
    logic signed [31:0] normal_y;
    logic signed [31:0] normal_z;
  } vertex_t;

  typedef struct packed {
    logic signed [31:0] new_x;
    logic signed [31:0] new_y;
    logic signed [31:0] new_z;
    logic               skipped;
    logic               saturated;
  } extruded_t;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  vertex_t            vtx;
  logic               out_valid;
  logic signed [31:0] out_new_x, out_new_y, out_new_z;
  logic               out_skipped, out_saturated;
  logic               psel, penable, pwrite;
  logic [1:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  logic [31:0] amount_copy;
  extruded_t   pending_vertices[$];
  int          mismatches;
  int          idle_pct;
  int          stall_cycles;

  vertex_normal_extrusion i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_pos_x     (vtx.pos_x),
    .in_pos_y     (vtx.pos_y),
    .in_pos_z     (vtx.pos_z),
    .in_normal_x  (vtx.normal_x),
    .in_normal_y  (vtx.normal_y),
    .in_normal_z  (vtx.normal_z),
    .out_valid    (out_valid),
    .out_new_x    (out_new_x),
    .out_new_y    (out_new_y),
    .out_new_z    (out_new_z),
    .out_skipped  (out_skipped),
    .out_saturated(out_saturated),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Magnitude of a 32-bit two's complement value, exact for the most negative
  function automatic longint unsigned mag32(logic [31:0] v);
    return v[31] ? ({32'd0, ~v} + 64'd1) : {32'd0, v};
  endfunction

  // Push a vertex along its unit normal by the current extrusion amount
  function automatic extruded_t extrude_vertex(vertex_t v, logic [31:0] amount);
    extruded_t          res;
    logic [31:0]        nrm[3];
    logic signed [31:0] pos[3];
    longint unsigned    nm[3];
    longint unsigned    m, s, len, amag, u, offm, rem, root, bt;
    longint             sum;
    logic               neg;
    int                 b;
    nrm = '{v.normal_x, v.normal_y, v.normal_z};
    pos = '{v.pos_x, v.pos_y, v.pos_z};
    res = '{v.pos_x, v.pos_y, v.pos_z, 1'b0, 1'b0};
    amag = mag32(amount);
    if (amag == 0) return res;
    m = 0;
    for (int i = 0; i < 3; i++) begin
      nm[i] = mag32(nrm[i]);
      if (nm[i] > m) m = nm[i];
    end
    if (m == 0) begin
      res.skipped = 1'b1;
      return res;
    end
    // scale the largest magnitude into [2^29, 2^30)
    b = 0;
    while (b < 64 && (m >> b) != 0) b++;
    s = 0;
    for (int i = 0; i < 3; i++) begin
      if (b > vne_pkg::NORM_BITS) nm[i] = nm[i] >> (b - vne_pkg::NORM_BITS);
      else nm[i] = nm[i] << (vne_pkg::NORM_BITS - b);
      s += nm[i] * nm[i];
    end
    // integer square root, one result bit per step
    rem = s;
    root = 0;
    bt = 64'd1 << 62;
    while (bt > rem) bt = bt >> 2;
    while (bt != 0) begin
      if (rem >= root + bt) begin
        rem = rem - (root + bt);
        root = (root >> 1) + bt;
      end else begin
        root = root >> 1;
      end
      bt = bt >> 2;
    end
    len = (root == 0) ? 64'd1 : root;
    for (int i = 0; i < 3; i++) begin
      u = (nm[i] << vne_pkg::NORM_BITS) / len;
      offm = (amag * u + (64'd1 << (vne_pkg::NORM_BITS - 1))) >> vne_pkg::NORM_BITS;
      neg = amount[31] ^ nrm[i][31];
      sum = longint'(pos[i]) + (neg ? -longint'(offm) : longint'(offm));
      if (sum > 64'sd2147483647) begin
        sum = 64'sd2147483647;
        res.saturated = 1'b1;
      end else if (sum < -64'sd2147483648) begin
        sum = -64'sd2147483648;
        res.saturated = 1'b1;
      end
      case (i)
        0: res.new_x = sum[31:0];
        1: res.new_y = sum[31:0];
        default: res.new_z = sum[31:0];
      endcase
    end
    return res;
  endfunction

  // Send one vertex, holding start until the block takes the beat
  task automatic send_vertex(vertex_t v);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    vtx   <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_vertices.push_back(extrude_vertex(v, amount_copy));
  endtask

  // Drain all results, then let the pipeline settle before a register write
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (pending_vertices.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_amount(logic [31:0] value);
    wait_idle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_EXTRUDE_AMOUNT;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    amount_copy = value;
  endtask

  // Mix full-range values with small, zero and extreme ones
  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 6))
      0:       return 32'h0;
      1:       return 32'h8000_0000;
      2:       return 32'h7fff_ffff;
      3:       return $urandom_range(0, 400) - 200;
      4:       return $signed($urandom()) >>> $urandom_range(0, 31);
      default: return $urandom();
    endcase
  endfunction

  function automatic vertex_t rand_vertex();
    vertex_t v;
    v.pos_x    = rand_coord();
    v.pos_y    = rand_coord();
    v.pos_z    = rand_coord();
    v.normal_x = rand_coord();
    v.normal_y = rand_coord();
    v.normal_z = rand_coord();
    // a zero normal now and then
    if ($urandom_range(0, 19) == 0) begin
      v.normal_x = '0;
      v.normal_y = '0;
      v.normal_z = '0;
    end
    return v;
  endfunction

  task automatic test_zero_amount();
    send_vertex('{32'h0001_0000, -32'sd5, 32'h8000_0000, 32'h0001_0000, 32'h0, 32'h0});
    send_vertex('{32'h7fff_ffff, 32'h1234_5678, 32'h0, 32'h0, 32'h0, 32'h0});
  endtask

  task automatic test_directed();
    write_amount(32'h0001_0000);
    send_vertex('{32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'h0});
    send_vertex('{32'h5, 32'h6, 32'h7, 32'h0, 32'h0, 32'h0});
    send_vertex('{32'h7fff_ffff, 32'h0, 32'h0, 32'h1, 32'h1, 32'h1});
    send_vertex('{32'h8000_0000, 32'h8000_0000, 32'h0, 32'h8000_0000, 32'hffff_ffff, 32'h0});
    send_vertex('{32'h0, 32'h0, 32'h0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
    send_vertex('{32'h0, 32'h0, 32'h0, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff});
    send_vertex('{32'h100, 32'h200, 32'h300, 32'h0003_0000, 32'hfffc_0000, 32'h0});
    write_amount(32'h7fff_ffff);
    send_vertex('{32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'h1, 32'hffff_ffff, 32'h0});
    send_vertex('{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h1});
    send_vertex('{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                  32'hffff_ffff});
    write_amount(32'h8000_0000);
    send_vertex('{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h8000_0000, 32'h8000_0000, 32'h0});
    send_vertex('{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h1, 32'h2, 32'h3});
    send_vertex('{32'h1, 32'h2, 32'h3, 32'h0, 32'h0, 32'h0});
    write_amount(32'hffff_ffff);
    send_vertex('{32'h8000_0000, 32'h0, 32'h0, 32'h1, 32'h0, 32'h0});
    send_vertex('{32'h0, 32'h0, 32'h0, 32'h0000_8000, 32'h0000_8000, 32'h0});
    write_amount(32'h1);
    send_vertex('{32'h0, 32'h0, 32'h0, 32'h5555_5555, 32'haaaa_aaaa, 32'h1});
  endtask

  task automatic test_random(int count, int pct);
    idle_pct = pct;
    for (int k = 0; k < count; k++) begin
      if (k % 150 == 0) begin
        case ($urandom_range(0, 4))
          0:       write_amount($urandom_range(0, 32'h0010_0000));
          1:       write_amount(-$urandom_range(0, 32'h0010_0000));
          2:       write_amount($urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000);
          3:       write_amount(32'h0);
          default: write_amount($urandom());
        endcase
      end
      send_vertex(rand_vertex());
    end
    idle_pct = 0;
  endtask

  // Check each result beat against the oldest prediction
  always @(posedge clk) begin
    extruded_t want, got;
    if (rst_n && out_valid) begin
      got = '{out_new_x, out_new_y, out_new_z, out_skipped, out_saturated};
      if (pending_vertices.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat: got %p", got);
      end else begin
        want = pending_vertices.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("result mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  // Watchdog: end the run when nothing is accepted for too long
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || psel) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    int drain;
    rst_n       = 1'b0;
    start       = 1'b0;
    vtx         = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    amount_copy = '0;
    mismatches  = 0;
    idle_pct    = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_zero_amount();
    test_directed();
    test_random(600, 10);
    test_random(600, 68);
    test_random(600, 0);

    // drain with a bound, then settle
    start <= 1'b0;
    drain = 0;
    while (pending_vertices.size() != 0 && drain < 10 * DRAIN_CYCLES) begin
      @(posedge clk);
      drain++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_vertices.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
